// ----- sv/law_pkg.sv -----
package law_pkg;

    localparam int SYM_CELLS  = 10;
    localparam int TIME_CELLS = 36;

    // lane of the symbol-count divider chain
    typedef struct packed {
        logic        valid;
        logic [3:0]  rem;
        logic [3:0]  dvs;
        logic [9:0]  nq;      // numerator shifts out on top, quotient shifts in below
        logic [3:0]  sf;
        logic [18:0] bw;
        logic [15:0] pre;
        logic [2:0]  cr;
    } sym_lane_t;

    typedef struct packed {
        logic        valid;
        logic [9:0]  sym;
        logic [18:0] quarters;
        logic [3:0]  sf;
        logic [18:0] bw;
    } quarter_stage_t;

    typedef struct packed {
        logic        valid;
        logic [9:0]  sym;
        logic [18:0] quarters;
        logic [18:0] bw;
        logic [33:0] base;
    } base_stage_t;

    typedef struct packed {
        logic        valid;
        logic [9:0]  sym;
        logic [18:0] quarters;
        logic [18:0] bw;
        logic [51:0] num_us;
        logic [41:0] num_wait;
    } prod_stage_t;

    // lane of the airtime divider chain: both divisions step together
    typedef struct packed {
        logic        valid;
        logic        sat_u;
        logic        sat_w;
        logic [18:0] bw;
        logic [18:0] ru;
        logic [20:0] rw;
        logic [35:0] nu;
        logic [35:0] nw;
        logic [9:0]  sym;
        logic [18:0] quarters;
    } time_lane_t;

endpackage

// ----- sv/lora_airtime_duty_wait_top.sv -----
// Each accepted word runs through every cell and stage to the output register.
// Throughput: one word per cycle; the whole pipeline holds while a result waits
// under out_stall, so in_stall follows out_valid and out_stall.
// Pipeline: 10 symbol-divider cells, 3 arithmetic stages, 36 airtime-divider cells.
// Reset: rst_n clears the cell and stage registers and out_valid asynchronously;
// the pipeline comes up empty.
module lora_airtime_duty_wait_top
    import law_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_len,
    input  logic [3:0]  spread_factor,
    input  logic [18:0] bandwidth_hz,
    input  logic [15:0] preamble_len,
    input  logic        implicit_header,
    input  logic        crc_on,
    input  logic [2:0]  coding_rate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  payload_symbols,
    output logic [18:0] airtime_quarter_symbols,
    output logic [35:0] airtime_us,
    output logic [21:0] duty_wait_s
);

    logic advance;

    // Advance everything unless a finished word is stuck at the output.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // ---------------- front: symbol numerator and divisor ----------------
    // num is always a multiple of four, so divide num/4 by den/4.
    logic       de;
    logic [3:0] dsym;
    logic [10:0] nsym;
    logic       npos;
    sym_lane_t  sym_chain [0:SYM_CELLS];

    always_comb
    begin
        de   = (spread_factor == 4'd11) || (spread_factor == 4'd12);
        dsym = de ? 4'(spread_factor - 4'd2) : spread_factor;
        nsym = 11'({2'b00, payload_len, 1'b0} + 11'd7 + (crc_on ? 11'd4 : 11'd0)
             - {7'b0, spread_factor} - (implicit_header ? 11'd5 : 11'd0));
        npos = !nsym[10] && (nsym != 11'd0) && (dsym != 4'd0);
        sym_chain[0].valid = in_valid;
        sym_chain[0].rem   = 4'd0;
        // zero divisor only occurs with a zero numerator; keep the step sane
        sym_chain[0].dvs   = (dsym == 4'd0) ? 4'd1 : dsym;
        // ceiling through floor((n + d - 1) / d); drop non-positive quotients
        sym_chain[0].nq    = npos ? 10'(nsym[9:0] + {6'b0, dsym} - 10'd1) : 10'd0;
        sym_chain[0].sf    = spread_factor;
        sym_chain[0].bw    = bandwidth_hz;
        sym_chain[0].pre   = preamble_len;
        sym_chain[0].cr    = coding_rate;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SYM_CELLS; gi++)
        begin : g_sym
            law_sym_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (sym_chain[gi]),
                .lane_out (sym_chain[gi+1])
            );
        end
    endgenerate

    // ---------------- symbol count and quarter symbols ----------------
    quarter_stage_t q_reg;
    quarter_stage_t q_next;
    logic [13:0]    extra;
    logic [9:0]     sym_val;

    always_comb
    begin
        extra   = 14'({4'b0, sym_chain[SYM_CELLS].nq}
                * {10'b0, 4'({1'b0, sym_chain[SYM_CELLS].cr} + 4'd4)});
        // saturate the symbol count at the field maximum
        sym_val = (extra > 14'd1015) ? 10'd1023 : 10'(extra + 14'd8);
        q_next.valid    = sym_chain[SYM_CELLS].valid;
        q_next.sym      = sym_val;
        q_next.quarters = {1'b0, sym_chain[SYM_CELLS].pre, 2'b00} + 19'd17
                        + {7'b0, sym_val, 2'b00};
        q_next.sf       = sym_chain[SYM_CELLS].sf;
        q_next.bw       = sym_chain[SYM_CELLS].bw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (advance)
        begin
            q_reg <= q_next;
        end
    end

    // ---------------- chips: scale by 2^sf ----------------
    base_stage_t b_reg;
    base_stage_t b_next;

    always_comb
    begin
        b_next.valid    = q_reg.valid;
        b_next.sym      = q_reg.sym;
        b_next.quarters = q_reg.quarters;
        b_next.bw       = q_reg.bw;
        b_next.base     = {15'b0, q_reg.quarters} << q_reg.sf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (advance)
        begin
            b_reg <= b_next;
        end
    end

    // ---------------- constant products ----------------
    // 250000 = 15625 * 16 and 15625 = 16384 - 1024 + 256 + 8 + 1; 99 = 64 + 32 + 2 + 1.
    prod_stage_t m_reg;
    prod_stage_t m_next;
    logic [51:0] bu;
    logic [41:0] bwide;

    always_comb
    begin
        bu    = {18'b0, b_reg.base};
        bwide = {8'b0, b_reg.base};
        m_next.valid    = b_reg.valid;
        m_next.sym      = b_reg.sym;
        m_next.quarters = b_reg.quarters;
        m_next.bw       = b_reg.bw;
        m_next.num_us   = ((bu << 14) - (bu << 10) + (bu << 8) + (bu << 3) + bu) << 4;
        // ceiling bias; with zero bandwidth the result saturates regardless
        m_next.num_wait = (bwide << 6) + (bwide << 5) + (bwide << 1) + bwide
                        + {21'b0, b_reg.bw, 2'b00} - 42'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (advance)
        begin
            m_reg <= m_next;
        end
    end

    // ---------------- airtime dividers ----------------
    // The top bits above the 36 quotient bits decide saturation: the quotient
    // overflows exactly when they reach the divisor. Zero bandwidth saturates too.
    time_lane_t time_chain [0:TIME_CELLS];
    logic       sat_u0;
    logic       sat_w0;

    always_comb
    begin
        sat_u0 = ({3'b0, m_reg.num_us[51:36]} >= m_reg.bw);
        sat_w0 = ({15'b0, m_reg.num_wait[41:36]} >= {m_reg.bw, 2'b00});
        time_chain[0].valid    = m_reg.valid;
        time_chain[0].sat_u    = sat_u0;
        time_chain[0].sat_w    = sat_w0;
        time_chain[0].bw       = m_reg.bw;
        time_chain[0].ru       = sat_u0 ? 19'd0 : {3'b0, m_reg.num_us[51:36]};
        time_chain[0].rw       = sat_w0 ? 21'd0 : {15'b0, m_reg.num_wait[41:36]};
        time_chain[0].nu       = m_reg.num_us[35:0];
        time_chain[0].nw       = m_reg.num_wait[35:0];
        time_chain[0].sym      = m_reg.sym;
        time_chain[0].quarters = m_reg.quarters;
    end

    genvar gj;
    generate
        for (gj = 0; gj < TIME_CELLS; gj++)
        begin : g_time
            law_time_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (time_chain[gj]),
                .lane_out (time_chain[gj+1])
            );
        end
    endgenerate

    // ---------------- output word register ----------------
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [9:0]  sym_reg;
    logic [18:0] quarters_reg;
    logic [35:0] us_reg;
    logic [35:0] us_next;
    logic [21:0] wait_reg;
    logic [21:0] wait_next;

    always_comb
    begin
        out_valid_next = time_chain[TIME_CELLS].valid;
        us_next   = time_chain[TIME_CELLS].sat_u ? '1 : time_chain[TIME_CELLS].nu;
        // clamp the wait to its field width
        wait_next = (time_chain[TIME_CELLS].sat_w
                    || (time_chain[TIME_CELLS].nw[35:22] != 14'd0))
                  ? '1 : time_chain[TIME_CELLS].nw[21:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sym_reg      <= time_chain[TIME_CELLS].sym;
            quarters_reg <= time_chain[TIME_CELLS].quarters;
            us_reg       <= us_next;
            wait_reg     <= wait_next;
        end
    end

    assign out_valid               = out_valid_reg;
    assign payload_symbols         = sym_reg;
    assign airtime_quarter_symbols = quarters_reg;
    assign airtime_us              = us_reg;
    assign duty_wait_s             = wait_reg;

    // ---------------- checks ----------------
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output holding");

    a_sym_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_symbols >= 10'd8))
        else $error("payload symbol count below eight");

    a_quarter_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (airtime_quarter_symbols[1:0] == 2'b01))
        else $error("quarter symbol count lost its fixed part");

    a_wait_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (airtime_us == 36'd0)) |-> (duty_wait_s <= 22'd1))
        else $error("duty wait inconsistent with zero airtime");

endmodule

// ----- sv/law_sym_cell.sv -----
module law_sym_cell
    import law_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  sym_lane_t lane_in,
    output sym_lane_t lane_out
);

    sym_lane_t  lane_reg;
    sym_lane_t  lane_next;
    logic [4:0] r2;
    logic       ge;

    // one restoring division step
    always_comb
    begin
        r2        = {lane_in.rem, lane_in.nq[9]};
        ge        = (r2 >= {1'b0, lane_in.dvs});
        lane_next = lane_in;
        lane_next.rem = ge ? 4'(r2 - {1'b0, lane_in.dvs}) : r2[3:0];
        lane_next.nq  = {lane_in.nq[8:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ----- sv/law_time_cell.sv -----
module law_time_cell
    import law_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  time_lane_t lane_in,
    output time_lane_t lane_out
);

    time_lane_t  lane_reg;
    time_lane_t  lane_next;
    logic [19:0] ru2;
    logic [21:0] rw2;
    logic        ge_u;
    logic        ge_w;

    // one quotient bit of each division
    always_comb
    begin
        ru2  = {lane_in.ru, lane_in.nu[35]};
        rw2  = {lane_in.rw, lane_in.nw[35]};
        ge_u = (ru2 >= {1'b0, lane_in.bw});
        ge_w = (rw2 >= {1'b0, lane_in.bw, 2'b00});
        lane_next    = lane_in;
        lane_next.ru = ge_u ? 19'(ru2 - {1'b0, lane_in.bw}) : ru2[18:0];
        lane_next.rw = ge_w ? 21'(rw2 - {1'b0, lane_in.bw, 2'b00}) : rw2[20:0];
        lane_next.nu = {lane_in.nu[34:0], ge_u};
        lane_next.nw = {lane_in.nw[34:0], ge_w};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // Every frame field the block can be handed, in port order.
    typedef struct packed {
        logic [7:0]  len;
        logic [3:0]  sf;
        logic [18:0] bw;
        logic [15:0] pre;
        logic        ih;
        logic        crc;
        logic [2:0]  cr;
    } frame_t;

    // The four values the block reports for one frame.
    typedef struct packed {
        logic [9:0]  sym;
        logic [18:0] quarters;
        logic [35:0] us;
        logic [21:0] wait_s;
    } airtime_t;

    localparam int  RANDOM_FRAMES = 1850;
    localparam int  STALL_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES  = 60;
    localparam logic [35:0] US_SAT   = '1;
    localparam logic [21:0] WAIT_SAT = '1;
    localparam logic [9:0]  SYM_SAT  = '1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  payload_len;
    logic [3:0]  spread_factor;
    logic [18:0] bandwidth_hz;
    logic [15:0] preamble_len;
    logic        implicit_header;
    logic        crc_on;
    logic [2:0]  coding_rate;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  payload_symbols;
    logic [18:0] airtime_quarter_symbols;
    logic [35:0] airtime_us;
    logic [21:0] duty_wait_s;

    lora_airtime_duty_wait_top DUT (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .payload_len             (payload_len),
        .spread_factor           (spread_factor),
        .bandwidth_hz            (bandwidth_hz),
        .preamble_len            (preamble_len),
        .implicit_header         (implicit_header),
        .crc_on                  (crc_on),
        .coding_rate             (coding_rate),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .payload_symbols         (payload_symbols),
        .airtime_quarter_symbols (airtime_quarter_symbols),
        .airtime_us              (airtime_us),
        .duty_wait_s             (duty_wait_s)
    );

    // Expected airtime results, oldest first.
    airtime_t pending_airtime[$];
    int       mismatches;
    int       frames_sent;
    int       results_seen;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact integer time-on-air: symbol count, quarter symbols, microseconds
    // truncated, and the duty-cycle wait rounded up; symbol count and both times saturated.
    function automatic airtime_t frame_airtime(frame_t f);
        airtime_t    r;
        int          de;
        int          num;
        int          den;
        int          q;
        int          extra;
        int          sym;
        logic [63:0] quarters;
        logic [63:0] base;
        logic [63:0] us;
        logic [63:0] wt;
        logic [63:0] bw64;
        begin
            de  = (f.sf == 11 || f.sf == 12) ? 1 : 0;
            num = 8 * int'(f.len) - 4 * int'(f.sf) + 28 + 16 * int'(f.crc)
                  - 20 * int'(f.ih);
            den = 4 * (int'(f.sf) - 2 * de);
            q = 0;
            if (den > 0)
            begin
                if (num >= 0)
                    q = (num + den - 1) / den;
                else
                    q = -((-num) / den);
            end
            sym = 8;
            if (q > 0)
            begin
                extra = q * (int'(f.cr) + 4);
                sym = (extra > 1023 - 8) ? 1023 : 8 + extra;
            end
            quarters = 64'(4 * int'(f.pre) + 17 + 4 * sym);
            base = quarters << f.sf;
            bw64 = 64'(f.bw);
            if (f.bw == 0)
            begin
                us = 64'(US_SAT);
                wt = 64'(WAIT_SAT);
            end
            else
            begin
                us = (base * 250000) / bw64;
                if (us > 64'(US_SAT))
                    us = 64'(US_SAT);
                wt = (base * 99 + 4 * bw64 - 1) / (4 * bw64);
                if (wt > 64'(WAIT_SAT))
                    wt = 64'(WAIT_SAT);
            end
            r.sym      = sym[9:0];
            r.quarters = quarters[18:0];
            r.us       = us[35:0];
            r.wait_s   = wt[21:0];
            return r;
        end
    endfunction

    // Present one word and hold it until accepted; valid drops only when the
    // sender idles, and the caller drops it after the last word.
    task automatic send_frame(frame_t f);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid        <= 1'b1;
            payload_len     <= f.len;
            spread_factor   <= f.sf;
            bandwidth_hz    <= f.bw;
            preamble_len    <= f.pre;
            implicit_header <= f.ih;
            crc_on          <= f.crc;
            coding_rate     <= f.cr;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_airtime.push_back(frame_airtime(f));
            frames_sent++;
            @(negedge clk);
        end
    endtask

    // Random frame: mostly legal settings, sometimes anything the ports hold.
    function automatic frame_t random_frame();
        frame_t f;
        begin
            f = frame_t'({$urandom, $urandom});
            if ($urandom_range(9) < 8)
            begin
                f.sf = 4'($urandom_range(12, 6));
                f.cr = 3'($urandom_range(4, 1));
                case ($urandom_range(3))
                    0: f.bw = 19'd125000;
                    1: f.bw = 19'd250000;
                    2: f.bw = 19'd500000;
                    default: f.bw = 19'($urandom_range(500000, 7800));
                endcase
                if ($urandom_range(3) != 0)
                    f.pre = 16'($urandom_range(64));
            end
            return f;
        end
    endfunction

    // Receiver: stall at random, compare every accepted word with the oldest
    // expectation.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        airtime_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_airtime.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else
            begin
                exp_r = pending_airtime.pop_front();
                if (payload_symbols !== exp_r.sym)
                begin
                    $error("payload_symbols: expected %0d, got %0d",
                           exp_r.sym, payload_symbols);
                    mismatches++;
                end
                if (airtime_quarter_symbols !== exp_r.quarters)
                begin
                    $error("airtime_quarter_symbols: expected %0d, got %0d",
                           exp_r.quarters, airtime_quarter_symbols);
                    mismatches++;
                end
                if (airtime_us !== exp_r.us)
                begin
                    $error("airtime_us: expected %0d, got %0d", exp_r.us, airtime_us);
                    mismatches++;
                end
                if (duty_wait_s !== exp_r.wait_s)
                begin
                    $error("duty_wait_s: expected %0d, got %0d",
                           exp_r.wait_s, duty_wait_s);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[lora_airtime_duty_wait_top] ERROR");
            $finish;
        end
    end

    // Directed frames; a row with check set also carries a hand-read result.
    typedef struct {
        frame_t   f;
        bit       check;
        airtime_t r;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic add_row(frame_t f, bit check, airtime_t r);
        directed_row_t row;
        begin
            row.f = f;
            row.check = check;
            row.r = r;
            directed_rows.push_back(row);
        end
    endtask

    initial
    begin
        frame_t f;
        airtime_t hand;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        out_stall       = 1'b0;
        payload_len     = '0;
        spread_factor   = '0;
        bandwidth_hz    = '0;
        preamble_len    = '0;
        implicit_header = 1'b0;
        crc_on          = 1'b0;
        coding_rate     = '0;
        mismatches      = 0;
        frames_sent     = 0;
        results_seen    = 0;
        idle_cycles     = 0;
        send_idle_pct   = 36;
        recv_idle_pct   = 58;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Spreading factor zero: symbol count stays at eight, quarters 49.
        f = '{len: 8'd10, sf: 4'd0, bw: 19'd125000, pre: 16'd0, ih: 1'b0,
              crc: 1'b0, cr: 3'd1};
        hand = '{sym: 10'd8, quarters: 19'd49, us: 36'd98, wait_s: 22'd1};
        add_row(f, 1'b1, hand);
        // Bandwidth zero: both times saturate.
        f.sf = 4'd7; f.bw = '0;
        hand = frame_airtime(f);
        hand.us = US_SAT; hand.wait_s = WAIT_SAT;
        add_row(f, 1'b1, hand);
        // Out-of-range spreading factor with a long payload: symbol count saturates.
        f = '{len: 8'd255, sf: 4'd1, bw: 19'd7800, pre: 16'hFFFF, ih: 1'b0,
              crc: 1'b1, cr: 3'd7};
        hand = frame_airtime(f);
        hand.sym = SYM_SAT;
        add_row(f, 1'b1, hand);
        // Airtime too large: SF15 at the smallest bandwidth.
        f = '{len: 8'd255, sf: 4'd15, bw: 19'd1, pre: 16'hFFFF, ih: 1'b1,
              crc: 1'b1, cr: 3'd4};
        hand = frame_airtime(f);
        hand.us = US_SAT; hand.wait_s = WAIT_SAT;
        add_row(f, 1'b1, hand);
        // Negative numerator: empty implicit payload at SF12.
        add_row('{8'd0, 4'd12, 19'd125000, 16'd8, 1'b1, 1'b0, 3'd1}, 1'b0, hand);
        add_row('{8'd0, 4'd6, 19'd500000, 16'd0, 1'b1, 1'b0, 3'd0}, 1'b0, hand);
        add_row('{8'd255, 4'd11, 19'd7800, 16'd6, 1'b0, 1'b1, 3'd4}, 1'b0, hand);
        add_row('{8'd255, 4'd12, 19'h7FFFF, 16'hFFFF, 1'b0, 1'b1, 3'd4}, 1'b0, hand);
        add_row('{8'd51, 4'd10, 19'd250000, 16'd8, 1'b0, 1'b1, 3'd2}, 1'b0, hand);
        add_row('{8'd20, 4'd9, 19'd125000, 16'd12, 1'b1, 1'b0, 3'd3}, 1'b0, hand);
        add_row('{8'd100, 4'd8, 19'd41700, 16'd8, 1'b0, 1'b0, 3'd5}, 1'b0, hand);
        add_row('{8'd1, 4'd13, 19'd62500, 16'd1, 1'b0, 1'b1, 3'd6}, 1'b0, hand);
        add_row('{8'd200, 4'd14, 19'd20800, 16'd300, 1'b1, 1'b1, 3'd7}, 1'b0, hand);
        add_row('{8'd128, 4'd5, 19'd31250, 16'h8000, 1'b1, 1'b0, 3'd2}, 1'b0, hand);

        foreach (directed_rows[i])
        begin
            send_frame(directed_rows[i].f);
            // Override the predicted entry with the hand-read one where given.
            if (directed_rows[i].check)
                pending_airtime[pending_airtime.size() - 1] = directed_rows[i].r;
        end
        in_valid <= 1'b0;

        // Hold the sender until the pipeline has drained completely.
        while (pending_airtime.size() != 0)
            @(negedge clk);

        for (int i = 0; i < RANDOM_FRAMES; i++)
        begin
            if (i == RANDOM_FRAMES / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 36;
            end
            if (i == 2 * RANDOM_FRAMES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_frame(random_frame());
        end
        in_valid <= 1'b0;

        while (pending_airtime.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d frames sent (directed edge cases and random), %0d results checked",
                 frames_sent, results_seen);
        $display("covered SF 0..15, zero and extreme bandwidths, saturation, all stall mixes");
        if (mismatches == 0)
            $display("[lora_airtime_duty_wait_top] OK");
        else
            $display("[lora_airtime_duty_wait_top] ERROR");
        $finish;
    end

endmodule

// ----- lora_airtime_duty_wait_top.f -----
sv/law_pkg.sv
sv/law_sym_cell.sv
sv/law_time_cell.sv
sv/lora_airtime_duty_wait_top.sv
tb/tb_top.sv
